@@ rtl/tbc64_pkg.sv @@
// shared types, constants and round functions for the 64-bit toy block cipher
package tbc64_pkg;

  localparam int ROUNDS    = 5;
  localparam int RND_W     = 4;
  localparam int BLK_W     = 64;
  localparam int KLEN_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = CFG_IDX_W'(1);

  // byte i moves to position PERM_DST[i]
  localparam logic [2:0] PERM_DST [8] = '{3'd7, 3'd0, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4, 3'd3};

  typedef struct packed {
    logic             opcode;
    logic [BLK_W-1:0] blk;
  } blk_item_t;

  function automatic logic [7:0] rotl8(logic [7:0] v, logic [2:0] n);
    logic [15:0] t;
    t = {v, v} << n;
    return t[15:8];
  endfunction

  function automatic logic [7:0] rotr8(logic [7:0] v, logic [2:0] n);
    logic [15:0] t;
    t = {v, v} >> n;
    return t[7:0];
  endfunction

  // i mod len for i < 8; zero length acts as one, eight or more leaves i
  function automatic logic [2:0] key_index(logic [2:0] i, logic [KLEN_W-1:0] len);
    logic [2:0] k;
    logic [2:0] l;
    k = i;
    l = len[2:0];
    if (len == '0 || len == KLEN_W'(1)) begin
      k = 3'd0;
    end else if (len < KLEN_W'(8)) begin
      for (int s = 0; s < 7; s++) begin
        if (k >= l) k = k - l;
      end
    end
    return k;
  endfunction

  function automatic logic [7:0] subkey(logic [RND_W-1:0] r, logic [BLK_W-1:0] kexp, int i);
    return 8'(r) + kexp[8*i +: 8] + 8'(i * i);
  endfunction

  function automatic logic [BLK_W-1:0] enc_round(logic [BLK_W-1:0] blk,
                                                 logic [BLK_W-1:0] kexp,
                                                 logic [RND_W-1:0] r);
    logic [7:0] b [8];
    logic [BLK_W-1:0] res;
    logic [7:0] r7;
    r7  = 8'(r) * 8'd7;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      b[i] = (blk[8*i +: 8] ^ subkey(r, kexp, i)) + 8'(i * i) + r7;
      b[i] = rotl8(b[i], 3'(i + 1));
    end
    for (int i = 1; i < 8; i++) begin
      b[i] = b[i] ^ b[i-1];
    end
    for (int i = 0; i < 8; i++) begin
      res[8*PERM_DST[i] +: 8] = b[i];
    end
    return res;
  endfunction

  function automatic logic [BLK_W-1:0] dec_round(logic [BLK_W-1:0] blk,
                                                 logic [BLK_W-1:0] kexp,
                                                 logic [RND_W-1:0] r);
    logic [7:0] t [8];
    logic [7:0] u [8];
    logic [BLK_W-1:0] res;
    logic [7:0] r7;
    r7  = 8'(r) * 8'd7;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      t[i] = blk[8*PERM_DST[i] +: 8];
    end
    u[0] = t[0];
    for (int i = 1; i < 8; i++) begin
      u[i] = t[i] ^ t[i-1];
    end
    for (int i = 0; i < 8; i++) begin
      u[i] = rotr8(u[i], 3'(i + 1));
      res[8*i +: 8] = (u[i] - 8'(i * i) - r7) ^ subkey(r, kexp, i);
    end
    return res;
  endfunction

endpackage

@@ rtl/tbc64_in_if.sv @@
// input channel: opcode and data block with valid/ready
interface tbc64_in_if;
  import tbc64_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [BLK_W-1:0] data_block;
  modport source (output valid, output opcode, output data_block, input ready);
  modport sink   (input valid, input opcode, input data_block, output ready);
endinterface

@@ rtl/tbc64_out_if.sv @@
// output channel: result block with valid/ready
interface tbc64_out_if;
  import tbc64_pkg::*;
  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] result_block;
  modport source (output valid, output result_block, input ready);
  modport sink   (input valid, input result_block, output ready);
endinterface

@@ rtl/tbc64_cfg_if.sv @@
// configuration write channel: register index and write data
interface tbc64_cfg_if;
  import tbc64_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BLK_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tbc64_cfg.sv @@
// key registers and key expansion into per-position key bytes
module tbc64_cfg
  import tbc64_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  tbc64_cfg_if.sink        cfg,
  output logic [BLK_W-1:0] kexp
);

  logic [BLK_W-1:0]  key_bytes;
  logic [KLEN_W-1:0] key_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes  <= '0;
      key_length <= KLEN_W'(8);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KEY_BYTES:  key_bytes  <= cfg.data;
        REG_KEY_LENGTH: key_length <= cfg.data[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    kexp = '0;
    for (int i = 0; i < 8; i++) begin
      kexp[8*i +: 8] = key_bytes[8*key_index(3'(i), key_length) +: 8];
    end
  end

endmodule

@@ rtl/tbc64_stage.sv @@
// one pipeline stage: one encrypt or decrypt round with valid/ready
module tbc64_stage
  import tbc64_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [RND_W-1:0] round_idx,
  input  logic [BLK_W-1:0] kexp,
  input  logic             in_valid,
  output logic             in_ready,
  input  blk_item_t        in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output blk_item_t        out_item
);

  logic [RND_W-1:0] dec_idx;
  blk_item_t        item_next;

  // decryption walks the rounds from last to first
  assign dec_idx  = RND_W'(ROUNDS - 1) - round_idx;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    item_next.opcode = in_item.opcode;
    if (in_item.opcode == OP_DECRYPT) begin
      item_next.blk = dec_round(in_item.blk, kexp, dec_idx);
    end else begin
      item_next.blk = enc_round(in_item.blk, kexp, round_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

@@ rtl/toy_block_cipher_64_unit.sv @@
// top level of the 64-bit toy block cipher: one round per pipeline stage
// throughput: one block per cycle; each stage holds one round and stalls only
//   when it is full and the stage after it cannot take its transaction
// reset (rst, synchronous): clears all stage valid bits, key to zero and
//   key length to eight; no clearing pass, ready again the cycle after reset
module toy_block_cipher_64_unit
  import tbc64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tbc64_in_if.sink   in_ch,
  tbc64_out_if.source out_ch,
  tbc64_cfg_if.sink  cfg
);

  // per-position key bytes; stable only if user configs while pipeline idle
  logic [BLK_W-1:0] kexp;

  // handshake chain between stages; index 0 is the input side
  logic      st_valid [ROUNDS+1];
  logic      st_ready [ROUNDS+1];
  blk_item_t st_item  [ROUNDS+1];

  tbc64_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .kexp (kexp)
  );

  // input transaction enters stage 0 directly
  assign st_valid[0]        = in_ch.valid;
  assign in_ch.ready        = st_ready[0];
  assign st_item[0].opcode  = in_ch.opcode;
  assign st_item[0].blk     = in_ch.data_block;

  // stage s runs encrypt round s or decrypt round ROUNDS-1-s
  for (genvar s = 0; s < ROUNDS; s++) begin : g_stage
    tbc64_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .round_idx (RND_W'(s)),
      .kexp      (kexp),
      .in_valid  (st_valid[s]),
      .in_ready  (st_ready[s]),
      .in_item   (st_item[s]),
      .out_valid (st_valid[s+1]),
      .out_ready (st_ready[s+1]),
      .out_item  (st_item[s+1])
    );
  end

  // last stage register doubles as the output register
  assign out_ch.valid        = st_valid[ROUNDS];
  assign st_ready[ROUNDS]    = out_ch.ready;
  assign out_ch.result_block = st_item[ROUNDS].blk;

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the 64-bit toy block cipher unit
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbc64_pkg::*;

  // register indexes that decode to nothing in the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  // destination position of each byte after diffusion
  localparam int BYTE_DEST [8] = '{7, 0, 6, 1, 5, 2, 4, 3};

  // receiver hold-off length for the backpressure phase
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic             op;
    logic [BLK_W-1:0] blk;
    int               gap;
  } block_req_t;

  logic clk = 1'b0;
  logic rst;

  tbc64_in_if  in_ch ();
  tbc64_out_if out_ch ();
  tbc64_cfg_if cfg_ch ();

  toy_block_cipher_64_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the key registers, updated on each accepted write
  logic [BLK_W-1:0]  key_q;
  logic [KLEN_W-1:0] key_len_q;

  block_req_t       block_q [$];       // blocks waiting to be offered
  logic [BLK_W-1:0] predicted_blocks [$];  // results still owed by the block

  int   mismatch_count = 0;
  bit   idle_on = 1'b1;    // random gaps on both sides when set
  bit   hold_req = 1'b0;   // starts the long receiver hold-off
  logic hold;

  // driver bookkeeping
  block_req_t cur_req;
  bit         in_have = 1'b0;
  int         in_wait = 0;

  // receiver bookkeeping
  int out_wait = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rot_left(logic [7:0] v, int n);
    n = n % 8;
    if (n == 0) return v;
    return (v << n) | (v >> (8 - n));
  endfunction

  function automatic logic [7:0] rot_right(logic [7:0] v, int n);
    n = n % 8;
    if (n == 0) return v;
    return (v >> n) | (v << (8 - n));
  endfunction

  // subkey byte i of round r; zero length wraps like one, 8 and up never wrap
  function automatic logic [7:0] round_key(int r, int i);
    int len;
    int k;
    len = int'(key_len_q);
    if (len == 0) len = 1;
    k = (i % len) & 7;
    return 8'(r + int'(key_q[8*k +: 8]) + i * i);
  endfunction

  function automatic logic [BLK_W-1:0] cipher_block(logic op, logic [BLK_W-1:0] blk);
    logic [7:0]       b [8];
    logic [7:0]       t [8];
    logic [BLK_W-1:0] res;
    int               r;
    for (int i = 0; i < 8; i++) b[i] = blk[8*i +: 8];
    if (op == OP_ENCRYPT) begin
      for (r = 0; r < ROUNDS; r++) begin
        // confusion, then per-byte rotate
        for (int i = 0; i < 8; i++) begin
          b[i] = rot_left(8'(int'(b[i] ^ round_key(r, i)) + i * i + 7 * r), i + 1);
        end
        // running xor chain
        for (int i = 1; i < 8; i++) b[i] = b[i] ^ b[i-1];
        for (int i = 0; i < 8; i++) t[BYTE_DEST[i]] = b[i];
        b = t;
      end
    end else begin
      for (r = ROUNDS - 1; r >= 0; r--) begin
        for (int i = 0; i < 8; i++) t[i] = b[BYTE_DEST[i]];
        // undo the chain from the top down
        for (int i = 7; i >= 1; i--) t[i] = t[i] ^ t[i-1];
        for (int i = 0; i < 8; i++) begin
          b[i] = 8'(int'(rot_right(t[i], i + 1)) - i * i - 7 * r) ^ round_key(r, i);
        end
      end
    end
    for (int i = 0; i < 8; i++) res[8*i +: 8] = b[i];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int idle_draw();
    return idle_on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  task automatic add_block(input logic op, input logic [BLK_W-1:0] blk);
    block_req_t req;
    req.op  = op;
    req.blk = blk;
    req.gap = idle_draw();
    block_q = {block_q, req};
  endtask

  // a block followed by its inverse, so the second one must give back the first
  task automatic add_round_trip(input logic op, input logic [BLK_W-1:0] blk);
    add_block(op, blk);
    add_block(op == OP_ENCRYPT ? OP_DECRYPT : OP_ENCRYPT, cipher_block(op, blk));
  endtask

  // config write, only issued while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BLK_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_KEY_BYTES) key_q = val;
    else if (idx == REG_KEY_LENGTH) key_len_q = val[KLEN_W-1:0];
  endtask

  // wait until every queued block has gone in and every result has come out
  task automatic drain();
    do @(negedge clk);
    while (block_q.size() != 0 || in_have || predicted_blocks.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers queued blocks, predicts on each accepted transaction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_have = 1'b0;
      in_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_blocks = {predicted_blocks,
                            cipher_block(in_ch.opcode, in_ch.data_block)};
        in_have = 1'b0;
      end
      if (!in_have && block_q.size() != 0) begin
        cur_req = block_q.pop_front();
        in_have = 1'b1;
        in_wait = cur_req.gap;
      end
      // one assignment to valid per edge, so back-to-back items keep it high
      if (in_have && in_wait == 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= cur_req.op;
        in_ch.data_block <= cur_req.blk;
      end else begin
        in_ch.valid <= 1'b0;
        if (in_have) in_wait = in_wait - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor: checks each result transaction and paces ready
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_blocks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result transaction: actual %h", out_ch.result_block);
          end
        end else if (predicted_blocks[0] !== out_ch.result_block) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected %h actual %h",
                     predicted_blocks[0], out_ch.result_block);
          end
          void'(predicted_blocks.pop_front());
        end else begin
          void'(predicted_blocks.pop_front());
        end
        out_wait = idle_draw();
      end
      // the long hold-off overrides the per-result gap
      if (hold) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_ch.ready <= 1'b0;
        out_wait = out_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver stall, counted here while the sender keeps offering blocks
  initial begin
    hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin
    int               len_plan [10];
    logic [BLK_W-1:0] val;
    logic [BLK_W-1:0] blk;
    int               n;
    int               pick;

    len_plan = '{8, 1, 0, 16, 3, 31, 5, 17, 7, 2};

    // known values on every input before the first edge
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_ENCRYPT;
    in_ch.data_block  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_KEY_BYTES;
    cfg_ch.data       = '0;
    key_q             = '0;
    key_len_q         = KLEN_W'(8);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset key, extreme and patterned blocks in both directions
    add_block(OP_ENCRYPT, '0);
    add_block(OP_DECRYPT, '0);
    add_block(OP_ENCRYPT, '1);
    add_block(OP_DECRYPT, '1);
    add_block(OP_ENCRYPT, 64'h0123_4567_89ab_cdef);
    add_block(OP_DECRYPT, 64'haaaa_aaaa_aaaa_aaaa);
    add_block(OP_ENCRYPT, 64'h5555_5555_5555_5555);
    add_round_trip(OP_ENCRYPT, 64'h8000_0000_0000_0001);
    drain();

    // all-ones key, zero length acting as one, junk above the length field,
    // writes to unused indexes that must change nothing
    write_reg(REG_KEY_BYTES, '1);
    val = {$urandom, $urandom};
    val[KLEN_W-1:0] = '0;
    write_reg(REG_KEY_LENGTH, val);
    write_reg(REG_SPARE_2, {$urandom, $urandom});
    write_reg(REG_SPARE_3, {$urandom, $urandom});
    add_round_trip(OP_ENCRYPT, {$urandom, $urandom});
    add_block(OP_DECRYPT, 64'hffff_ffff_0000_0000);
    add_block(OP_ENCRYPT, 64'h0000_0000_ffff_ffff);
    drain();

    // length above range behaves as a full eight-byte key
    write_reg(REG_KEY_BYTES, {$urandom, $urandom});
    val = {$urandom, $urandom};
    val[KLEN_W-1:0] = KLEN_W'(31);
    write_reg(REG_KEY_LENGTH, val);
    add_round_trip(OP_DECRYPT, {$urandom, $urandom});
    add_block(OP_ENCRYPT, 64'h00ff_00ff_00ff_00ff);
    drain();

    // random phases, each with its own key and length
    for (int ph = 0; ph < 10; ph++) begin
      // gap-free stretches on some phases, including the hold-off one
      idle_on = (ph % 3 != 2) && (ph != 4);
      if (ph == 0) val = '0;
      else if (ph == 1) val = '1;
      else val = {$urandom, $urandom};
      write_reg(REG_KEY_BYTES, val);
      val = {$urandom, $urandom};
      val[KLEN_W-1:0] = KLEN_W'(len_plan[ph]);
      write_reg(REG_KEY_LENGTH, val);
      if (ph % 2 == 1) write_reg(ph % 4 == 1 ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});

      // receiver stalls while a gap-free burst keeps coming
      if (ph == 4) hold_req = 1'b1;

      n = 0;
      while (n < 60) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          add_round_trip($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT,
                         {$urandom, $urandom});
          n += 2;
        end else if (pick == 4) begin
          // bytes drawn from edge values or at random
          for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 4))
              0:       blk[8*i +: 8] = 8'h00;
              1:       blk[8*i +: 8] = 8'hff;
              2:       blk[8*i +: 8] = 8'h80;
              3:       blk[8*i +: 8] = 8'h01;
              default: blk[8*i +: 8] = 8'($urandom);
            endcase
          end
          add_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, blk);
          n++;
        end else begin
          add_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, {$urandom, $urandom});
          n++;
        end
      end
      drain();
    end

    // pipeline is five rounds deep; give it time to show any stray result
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && predicted_blocks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (predicted_blocks.size() != 0) begin
        $display("%0d expected results never arrived", predicted_blocks.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout waiting for the cipher unit");
    $display("== FAIL ==");
    $finish;
  end

endmodule
